// ===== rtl/pbm_pkg.sv =====
// shared types and constants for the ascii bitmap stream parser
// used by every rtl file of the block, depends on nothing
package pbm_pkg;

  // size limits
  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned DimW    = 13;   // holds 0 .. MaxDim
  localparam int unsigned IdxW    = 12;   // holds 0 .. MaxDim-1
  localparam int unsigned AccW    = 17;   // accum*10 + digit before saturation

  // queue between front and back
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = 2;
  localparam int unsigned QCntW   = 3;

  // characters
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    CmNone = 3'b001,  // not in a comment
    CmThru = 3'b010,  // drop through the newline
    CmUpto = 3'b100   // drop up to the newline, keep it
  } comment_e;

  typedef enum logic [3:0] {
    PhMagic  = 4'b0001,
    PhWidth  = 4'b0010,
    PhHeight = 4'b0100,
    PhPixels = 4'b1000
  } phase_e;

  typedef enum logic [3:0] {
    NumAwait = 4'b0001,
    NumPos   = 4'b0010,
    NumNeg   = 4'b0100,
    NumDone  = 4'b1000
  } num_e;

  // item handed from front to back
  typedef struct packed {
    logic [7:0] chr;
    logic       restart;  // first byte of a new file
    logic       pass;     // byte survives comment stripping
  } token_t;

  // queue status seen by the back
  typedef struct packed {
    logic   empty;
    token_t head;
  } q_stat_t;

endpackage

// ===== rtl/pbm_front.sv =====
// front part: comment stripping and classification of incoming bytes
// depends on pbm_pkg
module pbm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_in_i,
  input  logic            file_start_i,
  output logic            push_o,
  output pbm_pkg::token_t token_o
);

  pbm_pkg::comment_e cm_q, cm_d, cm_eff;
  logic              prev_nl_q, prev_nl_d, prev_eff;
  logic              is_nl, pass;

  assign is_nl    = (byte_in_i == pbm_pkg::ChNl);
  assign cm_eff   = file_start_i ? pbm_pkg::CmNone : cm_q;
  assign prev_eff = file_start_i | prev_nl_q;

  always_comb begin
    cm_d      = cm_q;
    prev_nl_d = prev_nl_q;
    pass      = 1'b0;
    if (accept_i) begin
      prev_nl_d = is_nl;
      case (cm_eff)
        pbm_pkg::CmThru: begin
          cm_d = is_nl ? pbm_pkg::CmNone : pbm_pkg::CmThru;
        end
        pbm_pkg::CmUpto: begin
          cm_d = is_nl ? pbm_pkg::CmNone : pbm_pkg::CmUpto;
          pass = is_nl;
        end
        pbm_pkg::CmNone: begin
          cm_d = pbm_pkg::CmNone;
          if (byte_in_i == pbm_pkg::ChHash) begin
            cm_d = prev_eff ? pbm_pkg::CmThru : pbm_pkg::CmUpto;
          end else begin
            pass = 1'b1;
          end
        end
        default: begin
          cm_d = pbm_pkg::CmNone;
        end
      endcase
    end
  end

  // a restart byte always goes through so the back can clear its state
  assign push_o          = accept_i & (pass | file_start_i);
  assign token_o.chr     = byte_in_i;
  assign token_o.restart = file_start_i;
  assign token_o.pass    = pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q      <= pbm_pkg::CmNone;
      prev_nl_q <= 1'b1;
    end else begin
      cm_q      <= cm_d;
      prev_nl_q <= prev_nl_d;
    end
  end

endmodule

// ===== rtl/pbm_queue.sv =====
// short token queue between front and back
// depends on pbm_pkg
module pbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pbm_pkg::token_t   token_i,
  input  logic              pop_i,
  output logic              full_o,
  output pbm_pkg::q_stat_t  stat_o
);

  pbm_pkg::token_t                 mem_q [pbm_pkg::QDepth];
  logic [pbm_pkg::QAw-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [pbm_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign full_o       = (cnt_q == pbm_pkg::QCntW'(pbm_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/pbm_back.sv =====
// back part: header numbers, pixel placement and the output register
// depends on pbm_pkg
module pbm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbm_pkg::q_stat_t            stat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  pixel_char_o,
  output logic [pbm_pkg::IdxW-1:0]    row_o,
  output logic [pbm_pkg::IdxW-1:0]    col_o,
  output logic [pbm_pkg::DimW-1:0]    image_width_o,
  output logic [pbm_pkg::DimW-1:0]    image_height_o,
  output logic                        last_pixel_o
);

  pbm_pkg::phase_e              ph_q, ph_d, ph_e;
  pbm_pkg::num_e                num_q, num_d, num_e;
  logic [pbm_pkg::DimW-1:0]     acc_q, acc_d, acc_e;
  logic [pbm_pkg::DimW-1:0]     wid_q, wid_d, wid_e;
  logic [pbm_pkg::DimW-1:0]     hgt_q, hgt_d, hgt_e;
  logic [pbm_pkg::IdxW-1:0]     row_q, row_d, row_e;
  logic [pbm_pkg::IdxW-1:0]     col_q, col_d, col_e;
  logic                         done_q, done_d, done_e;
  logic                         ov_q, ov_d;
  logic [7:0]                   pix_q;
  logic [pbm_pkg::IdxW-1:0]     orow_q, ocol_q;
  logic [pbm_pkg::DimW-1:0]     owid_q, ohgt_q;
  logic                         olast_q;

  pbm_pkg::token_t              tok;
  logic [7:0]                   c;
  logic                         is_nl, is_digit, is_space, emit, last, col_end;
  logic [pbm_pkg::AccW-1:0]     acc_mul;
  logic [pbm_pkg::DimW-1:0]     acc_sat, num_val;
  logic [pbm_pkg::DimW-1:0]     col_inc, row_inc;

  assign tok   = stat_i.head;
  assign c     = tok.chr;
  assign pop_o = !stat_i.empty && (!ov_q || !out_stall_i);

  assign is_nl    = (c == pbm_pkg::ChNl);
  assign is_digit = (c >= pbm_pkg::ChZero) && (c <= pbm_pkg::ChNine);
  assign is_space = (c == pbm_pkg::ChSpace) || (c == pbm_pkg::ChTab) ||
                    (c == pbm_pkg::ChVt) || (c == pbm_pkg::ChFf) || (c == pbm_pkg::ChCr);

  // restart clears the parse before the byte itself is handled
  always_comb begin
    if (tok.restart) begin
      ph_e   = pbm_pkg::PhMagic;
      num_e  = pbm_pkg::NumAwait;
      acc_e  = '0;
      wid_e  = '0;
      hgt_e  = '0;
      row_e  = '0;
      col_e  = '0;
      done_e = 1'b0;
    end else begin
      ph_e   = ph_q;
      num_e  = num_q;
      acc_e  = acc_q;
      wid_e  = wid_q;
      hgt_e  = hgt_q;
      row_e  = row_q;
      col_e  = col_q;
      done_e = done_q;
    end
  end

  // accum*10 + digit, saturated
  assign acc_mul = {acc_e, 3'b000} + {2'b00, acc_e, 1'b0} +
                   pbm_pkg::AccW'(c - pbm_pkg::ChZero);
  assign acc_sat = (acc_mul > pbm_pkg::AccW'(pbm_pkg::MaxDim)) ?
                   pbm_pkg::DimW'(pbm_pkg::MaxDim) : acc_mul[pbm_pkg::DimW-1:0];
  assign num_val = (num_e == pbm_pkg::NumNeg) ? '0 : acc_e;

  assign col_inc = {1'b0, col_e} + 1'b1;
  assign row_inc = {1'b0, row_e} + 1'b1;
  assign col_end = (col_inc == wid_e);
  assign last    = col_end && (row_inc == hgt_e);

  always_comb begin
    ph_d   = ph_q;
    num_d  = num_q;
    acc_d  = acc_q;
    wid_d  = wid_q;
    hgt_d  = hgt_q;
    row_d  = row_q;
    col_d  = col_q;
    done_d = done_q;
    emit   = 1'b0;
    if (pop_o) begin
      ph_d   = ph_e;
      num_d  = num_e;
      acc_d  = acc_e;
      wid_d  = wid_e;
      hgt_d  = hgt_e;
      row_d  = row_e;
      col_d  = col_e;
      done_d = done_e;
      if (tok.pass) begin
        case (ph_e)
          pbm_pkg::PhMagic: begin
            if (is_nl) begin
              ph_d  = pbm_pkg::PhWidth;
              num_d = pbm_pkg::NumAwait;
              acc_d = '0;
            end
          end
          pbm_pkg::PhWidth, pbm_pkg::PhHeight: begin
            if (is_nl) begin
              if (ph_e == pbm_pkg::PhWidth) begin
                wid_d = num_val;
                ph_d  = pbm_pkg::PhHeight;
              end else begin
                hgt_d  = num_val;
                ph_d   = pbm_pkg::PhPixels;
                row_d  = '0;
                col_d  = '0;
                done_d = 1'b0;
              end
              num_d = pbm_pkg::NumAwait;
              acc_d = '0;
            end else begin
              case (num_e)
                pbm_pkg::NumAwait: begin
                  if (c == pbm_pkg::ChPlus) begin
                    num_d = pbm_pkg::NumPos;
                  end else if (c == pbm_pkg::ChMinus) begin
                    num_d = pbm_pkg::NumNeg;
                  end else if (is_digit) begin
                    num_d = pbm_pkg::NumPos;
                    acc_d = acc_sat;
                  end else if (!is_space) begin
                    num_d = pbm_pkg::NumDone;
                  end
                end
                pbm_pkg::NumPos, pbm_pkg::NumNeg: begin
                  if (is_digit) begin
                    acc_d = acc_sat;
                  end else begin
                    num_d = pbm_pkg::NumDone;
                  end
                end
                default: begin
                  num_d = num_e;
                end
              endcase
            end
          end
          pbm_pkg::PhPixels: begin
            if (!is_nl && (c != pbm_pkg::ChSpace) && !done_e &&
                (wid_e != '0) && (hgt_e != '0)) begin
              emit = 1'b1;
              if (last) begin
                done_d = 1'b1;
              end else if (col_end) begin
                col_d = '0;
                row_d = row_inc[pbm_pkg::IdxW-1:0];
              end else begin
                col_d = col_inc[pbm_pkg::IdxW-1:0];
              end
            end
          end
          default: begin
            ph_d = ph_e;
          end
        endcase
      end
    end
  end

  assign ov_d = pop_o ? emit : (ov_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= pbm_pkg::PhMagic;
      num_q  <= pbm_pkg::NumAwait;
      acc_q  <= '0;
      wid_q  <= '0;
      hgt_q  <= '0;
      row_q  <= '0;
      col_q  <= '0;
      done_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      num_q  <= num_d;
      acc_q  <= acc_d;
      wid_q  <= wid_d;
      hgt_q  <= hgt_d;
      row_q  <= row_d;
      col_q  <= col_d;
      done_q <= done_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_q   <= c;
      orow_q  <= row_e;
      ocol_q  <= col_e;
      owid_q  <= wid_e;
      ohgt_q  <= hgt_e;
      olast_q <= last;
    end
  end

  assign out_valid_o    = ov_q;
  assign pixel_char_o   = pix_q;
  assign row_o          = orow_q;
  assign col_o          = ocol_q;
  assign image_width_o  = owid_q;
  assign image_height_o = ohgt_q;
  assign last_pixel_o   = olast_q;

endmodule

// ===== rtl/ascii_pbm_stream_parser_unit.sv =====
// top level of the ascii bitmap stream parser: front, token queue, back
// depends on pbm_pkg, pbm_front, pbm_queue and pbm_back
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   byte_in_i, file_start_i
//   out      output     out_valid_o/out_stall_i pixel_char_o, row_o, col_o,
//                                               image_width_o, image_height_o,
//                                               last_pixel_o
//
// one byte a clock is accepted unless the queue is full; a pixel enters the output
// register in the cycle after the back takes its byte, and the back takes one token a clock
// unless a held pixel is stalled; the four-entry token queue sets how long the front runs on while out stalls
// reset (rst_ni low) clears the parse to the start of the magic line
// in_stall_o rises only when the queue is full; a byte dropped by comment
// stripping never enters the queue, except a file-start byte
module ascii_pbm_stream_parser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  byte_in_i,
  input  logic                        file_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  pixel_char_o,
  output logic [pbm_pkg::IdxW-1:0]    row_o,
  output logic [pbm_pkg::IdxW-1:0]    col_o,
  output logic [pbm_pkg::DimW-1:0]    image_width_o,
  output logic [pbm_pkg::DimW-1:0]    image_height_o,
  output logic                        last_pixel_o
);

  logic             accept;   // byte taken this cycle
  logic             push;     // token written to the queue
  logic             pop;      // token consumed by the back
  logic             full;
  pbm_pkg::token_t  token;
  pbm_pkg::q_stat_t q_stat;

  // stall depends on registered queue fill only
  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  // comment stripping, restart flagging
  pbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_in_i    (byte_in_i),
    .file_start_i (file_start_i),
    .push_o       (push),
    .token_o      (token)
  );

  // decouples byte intake from output stalls
  pbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (token),
    .pop_i   (pop),
    .full_o  (full),
    .stat_o  (q_stat)
  );

  // header parsing and pixel placement
  pbm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stat_i         (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_char_o   (pixel_char_o),
    .row_o          (row_o),
    .col_o          (col_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// ===== tb/ascii_pbm_stream_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ascii bitmap stream parser (ascii_pbm_stream_parser_unit)
// depends on pbm_pkg for character codes, sizes and the parser state enums
// drives whole bitmap files byte by byte and checks every pixel against a local parse
module ascii_pbm_stream_parser_unit_tb;

  // run control
  localparam int CycleLimit  = 200000;  // far above the slowest correct run
  localparam int ItemTarget  = 910;     // stop starting new random files after this
  localparam int HoldCycles  = 80;      // long receiver hold-off, fills the token queue
  localparam int DrainCycles = 20;      // settle time once nothing is expected

  // leading blanks that the size parser skips
  localparam logic [7:0] Blanks [5] = '{pbm_pkg::ChSpace, pbm_pkg::ChTab, pbm_pkg::ChVt,
                                        pbm_pkg::ChFf, pbm_pkg::ChCr};

  // one expected pixel, field for field as on the output ports
  typedef struct packed {
    logic [7:0]               chr;
    logic [pbm_pkg::IdxW-1:0] row;
    logic [pbm_pkg::IdxW-1:0] col;
    logic [pbm_pkg::DimW-1:0] img_w;
    logic [pbm_pkg::DimW-1:0] img_h;
    logic                     last;
  } pixel_t;

  // dut connections, all inputs known from time zero
  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic [7:0]               byte_in_i    = 8'h00;
  logic                     file_start_i = 1'b0;
  logic                     out_stall_i  = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [7:0]               pixel_char_o;
  logic [pbm_pkg::IdxW-1:0] row_o;
  logic [pbm_pkg::IdxW-1:0] col_o;
  logic [pbm_pkg::DimW-1:0] image_width_o;
  logic [pbm_pkg::DimW-1:0] image_height_o;
  logic                     last_pixel_o;

  // local copy of the parse state
  pbm_pkg::phase_e          ph;
  pbm_pkg::comment_e        strip;
  pbm_pkg::num_e            nstate;
  bit                       prev_nl;
  logic [pbm_pkg::DimW-1:0] acc;
  logic [pbm_pkg::DimW-1:0] wid;
  logic [pbm_pkg::DimW-1:0] hgt;
  logic [pbm_pkg::IdxW-1:0] row_n;
  logic [pbm_pkg::IdxW-1:0] col_n;
  bit                       img_done;

  pixel_t     expected_pixels[$];  // pixels still owed by the dut, oldest first
  logic [7:0] file_bytes[$];       // the file being built for sending

  int  errors        = 0;
  int  cycle_count   = 0;
  int  items_sent    = 0;
  int  results_taken = 0;   // pixels accepted on the output side
  int  results_seen  = 0;   // receiver's own copy, one gap drawn per pixel
  int  hold_requests = 0;
  int  hold_taken    = 0;
  int  hold_left     = 0;
  int  rx_wait       = 0;
  bit  tx_idle       = 1'b1;
  bit  rx_idle       = 1'b1;

  ascii_pbm_stream_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .file_start_i  (file_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_char_o  (pixel_char_o),
    .row_o         (row_o),
    .col_o         (col_o),
    .image_width_o (image_width_o),
    .image_height_o(image_height_o),
    .last_pixel_o  (last_pixel_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pixel prediction
  // ---------------------------------------------------------------------------

  // back to the start of the magic line, as after reset or a file start
  function automatic void clear_parse();
    ph       = pbm_pkg::PhMagic;
    strip    = pbm_pkg::CmNone;
    nstate   = pbm_pkg::NumAwait;
    prev_nl  = 1'b1;
    acc      = '0;
    wid      = '0;
    hgt      = '0;
    row_n    = '0;
    col_n    = '0;
    img_done = 1'b0;
  endfunction

  // one accepted byte: strip comments, track the header, queue any pixel
  function automatic void parse_byte(input logic [7:0] c, input logic restart);
    bit     was_nl;
    bit     keep;
    bit     is_digit;
    bit     is_blank;
    bit     last;
    int     v;
    pixel_t px;
    if (restart) clear_parse();
    was_nl  = prev_nl;
    prev_nl = (c == pbm_pkg::ChNl);
    keep    = 1'b0;

    // comment stripping comes first, in every phase
    case (strip)
      pbm_pkg::CmThru: if (c == pbm_pkg::ChNl) strip = pbm_pkg::CmNone;
      pbm_pkg::CmUpto: if (c == pbm_pkg::ChNl) begin
        strip = pbm_pkg::CmNone;
        keep  = 1'b1;     // newline after a mid-line comment survives
      end
      default: if (c == pbm_pkg::ChHash) begin
        strip = was_nl ? pbm_pkg::CmThru : pbm_pkg::CmUpto;
      end else begin
        keep = 1'b1;
      end
    endcase
    if (!keep) return;

    case (ph)
      pbm_pkg::PhMagic: if (c == pbm_pkg::ChNl) begin
        ph     = pbm_pkg::PhWidth;
        acc    = '0;
        nstate = pbm_pkg::NumAwait;
      end
      pbm_pkg::PhWidth, pbm_pkg::PhHeight: if (c == pbm_pkg::ChNl) begin
        if (ph == pbm_pkg::PhWidth) begin
          wid = (nstate == pbm_pkg::NumNeg) ? '0 : acc;
          ph  = pbm_pkg::PhHeight;
        end else begin
          hgt      = (nstate == pbm_pkg::NumNeg) ? '0 : acc;
          ph       = pbm_pkg::PhPixels;
          row_n    = '0;
          col_n    = '0;
          img_done = 1'b0;
        end
        acc    = '0;
        nstate = pbm_pkg::NumAwait;
      end else begin
        // atoi style: blanks, one sign, digits, anything else ends it
        is_digit = (c >= pbm_pkg::ChZero) && (c <= pbm_pkg::ChNine);
        is_blank = (c == pbm_pkg::ChSpace) || (c == pbm_pkg::ChTab) ||
                   (c == pbm_pkg::ChVt) || (c == pbm_pkg::ChFf) || (c == pbm_pkg::ChCr);
        if (nstate == pbm_pkg::NumAwait) begin
          if (c == pbm_pkg::ChPlus) nstate = pbm_pkg::NumPos;
          else if (c == pbm_pkg::ChMinus) nstate = pbm_pkg::NumNeg;
          else if (is_digit) nstate = pbm_pkg::NumPos;
          else if (!is_blank) nstate = pbm_pkg::NumDone;
          if (!is_digit) return;
        end
        if (nstate == pbm_pkg::NumPos || nstate == pbm_pkg::NumNeg) begin
          if (is_digit) begin
            v   = int'(acc) * 10 + (int'(c) - int'(pbm_pkg::ChZero));
            acc = (v > int'(pbm_pkg::MaxDim)) ? pbm_pkg::DimW'(pbm_pkg::MaxDim) :
                                                pbm_pkg::DimW'(v);
          end else begin
            nstate = pbm_pkg::NumDone;
          end
        end
      end
      default: begin
        // pixel area: spaces and newlines are separators
        if (c == pbm_pkg::ChSpace || c == pbm_pkg::ChNl) return;
        if (img_done || wid == '0 || hgt == '0) return;
        last     = (int'(col_n) + 1 == int'(wid)) && (int'(row_n) + 1 == int'(hgt));
        px.chr   = c;
        px.row   = row_n;
        px.col   = col_n;
        px.img_w = wid;
        px.img_h = hgt;
        px.last  = last;
        expected_pixels.push_back(px);
        if (last) begin
          img_done = 1'b1;
        end else if (int'(col_n) + 1 == int'(wid)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end else begin
          col_n = col_n + 1'b1;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // file building
  // ---------------------------------------------------------------------------

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  // '#', a few random bytes, the closing newline
  function automatic void push_comment();
    logic [7:0] b;
    file_bytes.push_back(pbm_pkg::ChHash);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      file_bytes.push_back((b == pbm_pkg::ChNl) ? 8'h63 : b);
    end
    file_bytes.push_back(pbm_pkg::ChNl);
  endfunction

  // one width or height line in some atoi form; gives back the size it stands for
  function automatic int push_size_line();
    int v;
    repeat ($urandom_range(0, 2)) file_bytes.push_back(Blanks[$urandom_range(0, 4)]);
    case ($urandom_range(0, 9))
      0: begin           // negative, saturates to zero
        v = 0;
        file_bytes.push_back(pbm_pkg::ChMinus);
        push_text($sformatf("%0d", $urandom_range(0, 50)));
      end
      1: begin           // no digits at all
        v = 0;
        file_bytes.push_back(8'($urandom_range(97, 122)));
      end
      2: begin           // oversized
        v = pbm_pkg::MaxDim;
        push_text($sformatf("%0d", $urandom_range(pbm_pkg::MaxDim, 99999)));
      end
      3: begin
        v = 0;
        file_bytes.push_back(pbm_pkg::ChZero);
      end
      default: begin
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) file_bytes.push_back(pbm_pkg::ChPlus);
        if ($urandom_range(0, 4) == 0) file_bytes.push_back(pbm_pkg::ChZero);
        push_text($sformatf("%0d", v));
      end
    endcase
    // trailing junk or a mid-line comment, which brings its own newline
    case ($urandom_range(0, 7))
      0: begin
        push_text(" x");
        file_bytes.push_back(pbm_pkg::ChNl);
      end
      1: begin
        file_bytes.push_back(8'($urandom_range(97, 122)));
        file_bytes.push_back(pbm_pkg::ChNl);
      end
      2: push_comment();
      default: file_bytes.push_back(pbm_pkg::ChNl);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------------

  // offer one item, after a random gap when tx_idle is set, and hold it until it is taken
  task automatic send_item(input logic [7:0] c, input logic restart);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_in_i    <= c;
    file_start_i <= restart;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    parse_byte(c, restart);
    items_sent++;
  endtask

  // whole file, file start flagged on its first byte
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_item(file_bytes[i], i == 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall per pixel, plus an occasional long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HoldCycles;
    end
    if (results_seen != results_taken) begin
      results_seen = results_taken;
      rx_wait      = rx_idle ? $urandom_range(0, 3) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
    end
  endtask

  // every accepted pixel against the oldest expectation; also the run limit
  always @(posedge clk_i) begin
    pixel_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[ascii_pbm_stream_parser_unit] ERROR");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      results_taken++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, char", pixel_char_o, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_char_o != want.chr) report_mismatch("pixel_char", pixel_char_o, want.chr);
        if (row_o != want.row) report_mismatch("row", row_o, want.row);
        if (col_o != want.col) report_mismatch("col", col_o, want.col);
        if (image_width_o != want.img_w) begin
          report_mismatch("image_width", image_width_o, want.img_w);
        end
        if (image_height_o != want.img_h) begin
          report_mismatch("image_height", image_height_o, want.img_h);
        end
        if (last_pixel_o != want.last) report_mismatch("last_pixel", last_pixel_o, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // comment at file start, mid-line comments, blank and sign before a size,
  // junk after it, nul and 0xff pixels, comment among pixels, a surplus byte
  task automatic test_comments_and_extremes();
    file_bytes.delete();
    push_text("#\n\n+2#\n 1x\n");
    file_bytes.push_back(8'h00);
    push_text("#c\n");
    file_bytes.push_back(8'hFF);
    push_text("z");
    send_file();
  endtask

  // height saturates at the maximum, image stops short without any marker
  task automatic test_size_saturation();
    file_bytes.delete();
    push_text("\n1\n99999\nA");
    send_file();
  endtask

  // negative width and a height with no digits: no pixel at all
  task automatic test_zero_size();
    file_bytes.delete();
    push_text("\n-3\n\nA");
    send_file();
  endtask

  // receiver holds off while an 8x4 image streams in back to back
  task automatic test_output_hold();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_requests++;
    file_bytes.delete();
    push_text("P1\n8\n4\n");
    repeat (32) file_bytes.push_back(8'(pbm_pkg::ChZero + $urandom_range(0, 1)));
    send_file();
  endtask

  // mostly well-formed files with random header forms and pixel layout,
  // some pure noise and some cut short by the next file start
  task automatic test_random_files();
    int w;
    int h;
    int npix;
    int cut;
    while (items_sent < ItemTarget) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      file_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) push_comment();
        if ($urandom_range(0, 1) == 0) push_text("P1");
        else repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(65, 90)));
        if ($urandom_range(0, 4) == 0) push_comment();
        else file_bytes.push_back(pbm_pkg::ChNl);
        w = push_size_line();
        if ($urandom_range(0, 4) == 0) push_comment();
        h = push_size_line();
        npix = (w * h > 48) ? 48 : w * h;
        case ($urandom_range(0, 7))
          0: npix = $urandom_range(0, npix);
          1: npix = npix + $urandom_range(1, 4);
          default: ;
        endcase
        if (npix == 0) npix = $urandom_range(0, 3);
        for (int k = 0; k < npix; k++) begin
          case ($urandom_range(0, 11))
            0, 1, 2: file_bytes.push_back(pbm_pkg::ChSpace);
            3: file_bytes.push_back(pbm_pkg::ChNl);
            4: push_comment();
            default: ;
          endcase
          if ($urandom_range(0, 3) == 0) file_bytes.push_back(8'($urandom_range(0, 255)));
          else file_bytes.push_back(8'(pbm_pkg::ChZero + $urandom_range(0, 1)));
        end
        // restart in the middle of a file
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      end
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parse();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_comments_and_extremes();
    test_size_saturation();
    test_zero_size();
    test_output_hold();
    test_random_files();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // wait for the owed pixels, then a little longer for stray ones
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ascii_pbm_stream_parser_unit] OK");
    end else begin
      $display("[ascii_pbm_stream_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pbm_pkg.sv
rtl/pbm_front.sv
rtl/pbm_queue.sv
rtl/pbm_back.sv
rtl/ascii_pbm_stream_parser_unit.sv
tb/ascii_pbm_stream_parser_unit_tb.sv
